[hdl/frqs_pkg.sv]
package frqs_pkg;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_SETSTATE = 2'd1,
		ACT_TAIL     = 2'd2,
		ACT_HEAD     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		TS_READY   = 2'd0,
		TS_SUSPEND = 2'd1,
		TS_IDLE    = 2'd2,
		TS_OTHER   = 2'd3
	} task_state_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_TAIL  = 2'd1,
		OP_HEAD  = 2'd2,
		OP_SLEEP = 2'd3
	} list_op_t;

	typedef struct packed {
		logic     step;
		list_op_t op;
		logic     set_idle;
		logic     write_state;
		logic [1:0] state_val;
	} frqs_cmd_t;

	typedef struct packed {
		logic busy;
	} frqs_sts_t;

endpackage

[hdl/fifo_ready_queue_scheduler.sv]
// FIFO ready-queue scheduler for up to 16 task slots. Each accepted transaction
// names a task and an action (add, set state, to ready tail, to ready head) and
// returns one result with the picked task, ready count and the task's recorded
// state. The queue is a doubly linked list in flip-flops, so unlink and relink
// finish in the accept cycle: one transaction per cycle while the output is not
// stalled, result registered the next cycle. Reset needs no clearing pass.
module fifo_ready_queue_scheduler
	import frqs_pkg::*;
#(
	parameter int TASK_SLOTS = 16
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [3:0] task_id,
	input  logic       task_is_idle,
	input  logic [1:0] new_state,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] picked_task,
	output logic       picked_is_idle,
	output logic       no_task,
	output logic [4:0] ready_count,
	output logic [1:0] task_state_now
);

	localparam int Slots = (TASK_SLOTS > 16) ? 16 : TASK_SLOTS;
	localparam int IdW = (Slots > 1) ? $clog2(Slots) : 1;

	frqs_cmd_t cmd;
	logic      slot_ok;

	frqs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .action, .task_is_idle,
		.new_state, .slot_ok, .out_valid, .out_stall, .cmd
	);

	frqs_dp #(.TaskSlots(Slots), .IdW(IdW)) u_dp (
		.clk, .arst_n, .cmd, .task_id, .slot_ok, .out_valid, .out_stall,
		.picked_task, .picked_is_idle, .no_task, .ready_count, .task_state_now
	);

endmodule

[hdl/frqs_ctrl.sv]
module frqs_ctrl
	import frqs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic       task_is_idle,
	input  logic [1:0] new_state,
	input  logic       slot_ok,
	input  logic       out_valid,
	input  logic       out_stall,
	output frqs_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_HOLD = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// result register may be refilled when empty or being drained
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:  if (in_stall) state_d = ST_HOLD;
			ST_HOLD: if (!in_stall) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.step        = accept;
		cmd.op          = OP_NONE;
		cmd.state_val   = new_state;
		if (accept && slot_ok) begin
			unique case (action_t'(action))
				ACT_ADD: begin
					if (task_is_idle) begin
						cmd.set_idle = 1'b1;
					end else begin
						cmd.op          = OP_SLEEP;
						cmd.write_state = 1'b1;
						cmd.state_val   = TS_SUSPEND;
					end
				end
				ACT_SETSTATE: begin
					if (!task_is_idle) begin
						cmd.write_state = 1'b1;
						unique case (task_state_t'(new_state))
							TS_READY:   cmd.op = OP_TAIL;
							TS_SUSPEND: cmd.op = OP_SLEEP;
							TS_IDLE:    cmd.op = OP_SLEEP;
							default:    cmd.op = OP_NONE;
						endcase
					end
				end
				ACT_TAIL: if (!task_is_idle) cmd.op = OP_TAIL;
				default:  cmd.op = OP_HEAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> in_stall || !out_stall)
		else $error("hold state without stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.step |-> (cmd.op == OP_NONE && !cmd.write_state && !cmd.set_idle))
		else $error("command without accept");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_idle && cmd.write_state))
		else $error("idle record and state write together");

endmodule

[hdl/frqs_dp.sv]
module frqs_dp
	import frqs_pkg::*;
#(
	parameter int TaskSlots = 16,
	parameter int IdW = 4
)
(
	input  logic           clk,
	input  logic           arst_n,
	input  frqs_cmd_t      cmd,
	input  logic [3:0]     task_id,
	output logic           slot_ok,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [3:0]     picked_task,
	output logic           picked_is_idle,
	output logic           no_task,
	output logic [4:0]     ready_count,
	output logic [1:0]     task_state_now
);

	localparam int CntW = $clog2(TaskSlots + 1);

	logic [1:0]     mem_q [TaskSlots];
	logic [IdW-1:0] next_q [TaskSlots];
	logic [IdW-1:0] prev_q [TaskSlots];
	logic [1:0]     rstate_q [TaskSlots];
	logic [IdW-1:0] head_q, tail_q, idle_q;
	logic           idle_v_q;
	logic [CntW-1:0] len_q;

	logic [IdW-1:0] t, p, n, head_a, tail_a;
	logic [CntW-1:0] len_a, len_d;
	logic           queued;

	assign slot_ok = ({4'b0, task_id} < 8'(TaskSlots)) || (IdW > 4);
	assign t = IdW'(task_id);
	assign queued = mem_q[t] == 2'd1;
	assign p = prev_q[t];
	assign n = next_q[t];

	// state after unlink
	always_comb begin
		head_a = head_q;
		tail_a = tail_q;
		len_a  = len_q;
		if (queued) begin
			if (head_q == t) head_a = n;
			if (tail_q == t) tail_a = p;
			len_a = len_q - 1'b1;
		end
		len_d = len_a;
		if (cmd.op == OP_TAIL || cmd.op == OP_HEAD) len_d = len_a + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TaskSlots; i++) begin
				mem_q[i]    <= 2'd0;
				rstate_q[i] <= TS_OTHER;
			end
			head_q   <= '0;
			tail_q   <= '0;
			len_q    <= '0;
			idle_v_q <= 1'b0;
			idle_q   <= '0;
		end else begin
			if (cmd.set_idle) begin
				idle_q   <= t;
				idle_v_q <= 1'b1;
			end
			if (cmd.write_state) rstate_q[t] <= cmd.state_val;
			if (cmd.op != OP_NONE) begin
				head_q <= head_a;
				tail_q <= tail_a;
				len_q  <= len_d;
				unique case (cmd.op)
					OP_SLEEP: mem_q[t] <= 2'd2;
					OP_TAIL: begin
						mem_q[t] <= 2'd1;
						tail_q   <= t;
						if (len_a == '0) head_q <= t;
					end
					OP_HEAD: begin
						mem_q[t] <= 2'd1;
						head_q   <= t;
						if (len_a == '0) tail_q <= t;
					end
					default: ;
				endcase
			end
		end
	end

	// link arrays carry no reset
	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			if (queued) begin
				if (head_q != t) next_q[p] <= n;
				if (tail_q != t) prev_q[n] <= p;
			end
			if (cmd.op == OP_TAIL && len_a != '0) begin
				next_q[tail_a] <= t;
				prev_q[t]      <= tail_a;
			end
			if (cmd.op == OP_HEAD && len_a != '0) begin
				prev_q[head_a] <= t;
				next_q[t]      <= head_a;
			end
		end
	end

	// result register
	logic [1:0] st_now;
	logic [IdW-1:0] pick;
	always_comb begin
		st_now = cmd.write_state ? cmd.state_val : rstate_q[t];
		if (!slot_ok) st_now = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!(out_valid && out_stall)) begin
			out_valid <= cmd.step;
		end
	end

	logic [CntW-1:0] len_n;
	logic [IdW-1:0]  head_n;
	logic            idle_v_n;
	logic [IdW-1:0]  idle_n;
	always_comb begin
		len_n    = (cmd.op != OP_NONE) ? len_d : len_q;
		head_n   = head_q;
		if (cmd.op != OP_NONE) begin
			head_n = head_a;
			if (cmd.op == OP_HEAD || (cmd.op == OP_TAIL && len_a == '0)) head_n = t;
		end
		idle_v_n = cmd.set_idle || idle_v_q;
		idle_n   = cmd.set_idle ? t : idle_q;
		pick     = (len_n != '0) ? head_n : (idle_v_n ? idle_n : '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.step && !(out_valid && out_stall)) begin
			picked_task    <= 4'(pick);
			picked_is_idle <= (len_n == '0) && idle_v_n;
			no_task        <= (len_n == '0) && !idle_v_n;
			ready_count    <= 5'(len_n);
			task_state_now <= st_now;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CntW'(TaskSlots))
		else $error("ready length overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(picked_is_idle && no_task))
		else $error("idle and empty both flagged");
	assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0 && cmd.op == OP_TAIL) |=> (head_q == tail_q))
		else $error("single entry queue ends differ");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import frqs_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [3:0] task_sel;
		logic       idle_pick;
		logic       empty;
		logic [4:0] count;
		logic [1:0] state;
	} pick_t;

	typedef struct {
		action_t     act;
		logic [3:0]  id;
		logic        idle;
		task_state_t ns;
		logic        fixed;
		pick_t       want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [3:0] task_id;
	logic task_is_idle;
	logic [1:0] new_state;
	logic out_valid;
	logic out_stall;
	logic [3:0] picked_task;
	logic picked_is_idle;
	logic no_task;
	logic [4:0] ready_count;
	logic [1:0] task_state_now;

	fifo_ready_queue_scheduler #(.TASK_SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.task_id(task_id),
		.task_is_idle(task_is_idle),
		.new_state(new_state),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.picked_task(picked_task),
		.picked_is_idle(picked_is_idle),
		.no_task(no_task),
		.ready_count(ready_count),
		.task_state_now(task_state_now)
	);

	// scheduler mirror
	logic [1:0] mem_of [SLOTS];
	logic [3:0] nxt [SLOTS];
	logic [3:0] prv [SLOTS];
	logic [3:0] q_head;
	logic [3:0] q_tail;
	int q_len;
	logic idle_known;
	logic [3:0] idle_id;
	task_state_t task_state [SLOTS];

	pick_t pending_picks [$];
	int errors = 0;
	int cycles = 0;
	int tx_pct = 0;
	int rx_pct = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("fifo_ready_queue_scheduler regression: fail");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic void unlink(input logic [3:0] t);
		if (mem_of[t] == 2'd1) begin
			if (q_head == t) q_head = nxt[t]; else nxt[prv[t]] = nxt[t];
			if (q_tail == t) q_tail = prv[t]; else prv[nxt[t]] = prv[t];
			q_len--;
		end
		mem_of[t] = 2'd0;
	endfunction

	function automatic void enqueue(input logic [3:0] t, input logic at_head);
		unlink(t);
		if (q_len == 0) begin
			q_head = t;
			q_tail = t;
		end else if (at_head) begin
			prv[q_head] = t;
			nxt[t] = q_head;
			q_head = t;
		end else begin
			nxt[q_tail] = t;
			prv[t] = q_tail;
			q_tail = t;
		end
		q_len++;
		mem_of[t] = 2'd1;
	endfunction

	function automatic void park(input logic [3:0] t);
		unlink(t);
		mem_of[t] = 2'd2;
	endfunction

	function automatic pick_t schedule(input action_t a, input logic [3:0] t, input logic idle,
			input task_state_t ns);
		pick_t p;
		case (a)
			ACT_ADD: begin
				if (idle) begin
					idle_id = t;
					idle_known = 1'b1;
				end else begin
					park(t);
					task_state[t] = TS_SUSPEND;
				end
			end
			ACT_SETSTATE: begin
				if (!idle) begin
					if (ns == TS_READY) enqueue(t, 1'b0);
					else if (ns == TS_SUSPEND || ns == TS_IDLE) park(t);
					task_state[t] = ns;
				end
			end
			ACT_TAIL: if (!idle) enqueue(t, 1'b0);
			default: enqueue(t, 1'b1);
		endcase
		p.state = task_state[t];
		p.count = q_len[4:0];
		if (q_len > 0) begin
			p.task_sel = q_head;
			p.idle_pick = 1'b0;
			p.empty = 1'b0;
		end else if (idle_known) begin
			p.task_sel = idle_id;
			p.idle_pick = 1'b1;
			p.empty = 1'b0;
		end else begin
			p.task_sel = 4'd0;
			p.idle_pick = 1'b0;
			p.empty = 1'b1;
		end
		return p;
	endfunction

	// result checking
	always @(posedge clk) begin
		pick_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_picks.size() == 0) begin
				report("unexpected transaction", int'(picked_task), 0);
			end else begin
				w = pending_picks.pop_front();
				if (picked_task !== w.task_sel)
					report("picked_task", int'(picked_task), int'(w.task_sel));
				if (picked_is_idle !== w.idle_pick)
					report("picked_is_idle", int'(picked_is_idle), int'(w.idle_pick));
				if (no_task !== w.empty) report("no_task", int'(no_task), int'(w.empty));
				if (ready_count !== w.count)
					report("ready_count", int'(ready_count), int'(w.count));
				if (task_state_now !== w.state)
					report("task_state_now", int'(task_state_now), int'(w.state));
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_pct);
	end

	task automatic send(input action_t a, input logic [3:0] t, input logic idle,
			input task_state_t ns, input logic fixed, input pick_t want);
		pick_t p;
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		task_id <= t;
		task_is_idle <= idle;
		new_state <= ns;
		do @(posedge clk); while (in_stall);
		p = schedule(a, t, idle, ns);
		if (fixed && p != want) report("directed prediction", int'(p), int'(want));
		pending_picks.push_back(fixed ? want : p);
	endtask

	stim_row_t directed [$];

	function automatic stim_row_t row(input action_t a, input int t, input logic idle,
			input task_state_t ns, input logic fixed, input pick_t want);
		stim_row_t r;
		r.act = a; r.id = 4'(t); r.idle = idle; r.ns = ns; r.fixed = fixed; r.want = want;
		return r;
	endfunction

	initial begin
		int n;
		logic [3:0] rid;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 2'd0;
		task_id = 4'd0;
		task_is_idle = 1'b0;
		new_state = 2'd0;
		out_stall = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			mem_of[i] = 2'd0; nxt[i] = 4'd0; prv[i] = 4'd0; task_state[i] = TS_OTHER;
		end
		q_head = 4'd0; q_tail = 4'd0; q_len = 0; idle_known = 1'b0; idle_id = 4'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: nothing queued, no idle task
		directed.push_back(row(ACT_SETSTATE, 15, 1'b1, TS_READY, 1'b1,
			'{4'd0, 1'b0, 1'b1, 5'd0, TS_OTHER}));
		directed.push_back(row(ACT_ADD, 0, 1'b0, TS_OTHER, 1'b1,
			'{4'd0, 1'b0, 1'b1, 5'd0, TS_SUSPEND}));
		directed.push_back(row(ACT_ADD, 15, 1'b1, TS_IDLE, 1'b1,
			'{4'd15, 1'b1, 1'b0, 5'd0, TS_OTHER}));
		directed.push_back(row(ACT_TAIL, 15, 1'b1, TS_READY, 1'b1,
			'{4'd15, 1'b1, 1'b0, 5'd0, TS_OTHER}));
		directed.push_back(row(ACT_SETSTATE, 0, 1'b0, TS_READY, 1'b1,
			'{4'd0, 1'b0, 1'b0, 5'd1, TS_READY}));
		directed.push_back(row(ACT_TAIL, 5, 1'b0, TS_OTHER, 1'b0, '0));
		directed.push_back(row(ACT_HEAD, 9, 1'b0, TS_SUSPEND, 1'b0, '0));
		directed.push_back(row(ACT_TAIL, 9, 1'b0, TS_READY, 1'b0, '0));
		directed.push_back(row(ACT_HEAD, 5, 1'b0, TS_READY, 1'b0, '0));
		directed.push_back(row(ACT_HEAD, 5, 1'b0, TS_READY, 1'b0, '0));
		directed.push_back(row(ACT_HEAD, 15, 1'b1, TS_READY, 1'b0, '0));
		directed.push_back(row(ACT_SETSTATE, 9, 1'b0, TS_OTHER, 1'b0, '0));
		directed.push_back(row(ACT_SETSTATE, 9, 1'b0, TS_IDLE, 1'b0, '0));
		directed.push_back(row(ACT_SETSTATE, 5, 1'b0, TS_SUSPEND, 1'b0, '0));
		directed.push_back(row(ACT_ADD, 15, 1'b0, TS_READY, 1'b0, '0));
		directed.push_back(row(ACT_SETSTATE, 0, 1'b0, TS_SUSPEND, 1'b0, '0));
		directed.push_back(row(ACT_ADD, 3, 1'b1, TS_OTHER, 1'b0, '0));
		for (int i = 0; i < SLOTS; i++)
			directed.push_back(row(ACT_TAIL, i, 1'b0, TS_READY, 1'b0, '0));
		foreach (directed[i])
			send(directed[i].act, directed[i].id, directed[i].idle, directed[i].ns,
				directed[i].fixed, directed[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin tx_pct = 0; rx_pct = 0; end
				1: begin tx_pct = 52; rx_pct = 0; end
				2: begin tx_pct = 0; rx_pct = 52; end
				default: begin tx_pct = 26; rx_pct = 26; end
			endcase
			n = 0;
			while (n < 270) begin
				rid = 4'($urandom_range(15));
				if ($urandom_range(9) < 2) rid = 4'($urandom_range(3));
				send(action_t'($urandom_range(3)), rid, ($urandom_range(7) == 0),
					task_state_t'($urandom_range(3)), 1'b0, '0);
				n++;
			end
		end
		in_valid <= 1'b0;
		tx_pct = 0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("fifo_ready_queue_scheduler regression: pass");
		else
			$display("fifo_ready_queue_scheduler regression: fail");
		$finish;
	end

endmodule
